@@ hw/rtl/ppl_pkg.sv @@
// Shared types and constants for the Phong pixel lighting block.
// Used by the DUT, ppl_checker and the testbench; depends on nothing.
package ppl_pkg;

    // One fragment: camera-space position and raw normal, signed Q3.12
    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
    } t_in_item;

    // One lit pixel: unsigned Q4.12 per channel, saturated
    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_out_item;

    // Register indexes, register i at byte address 8*i
    typedef enum logic [2:0] {
        REG_LIGHT_POS,
        REG_INTENSITY,
        REG_AMBIENT,
        REG_DIFFUSE,
        REG_SPECULAR
    } t_reg_idx;

    localparam int          ADDR_W   = 6;
    localparam int          DATA_W   = 64;
    localparam int          REG_W    = 48;
    localparam logic [14:0] UNIT_ONE = 15'd16384;
    localparam logic [15:0] SAT_MAX  = 16'hFFFF;

endpackage

@@ hw/rtl/phong_pixel_lighting_top.sv @@
// Phong pixel lighting, one point light: fully pipelined shading datapath.
// Depends on ppl_pkg (item types, register indexes, constants).
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+---------------------------
//   fragment | in        | i_valid / o_stall  | i_in  (t_in_item)
//   pixel    | out       | o_valid / i_stall  | o_out (t_out_item)
//   config   | in        | APB psel/penable   | paddr, pwdata, prdata
//
// One transaction per cycle sustained while o_stall is low; the datapath holds
// the 27-step square root and the 16-step dividers.
// Synchronous active-low reset clears the valid bits of all stages and slots.
// The pipe freezes while the skid register holds a result, which happens when
// a result reaches a full output slot that is stalled; o_stall is registered.
module phong_pixel_lighting_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  ppl_pkg::t_in_item              i_in,
    output logic                           o_valid,
    input  logic                           i_stall,
    output ppl_pkg::t_out_item             o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ppl_pkg::ADDR_W-1:0]     paddr,
    input  logic [ppl_pkg::DATA_W-1:0]     pwdata,
    output logic [ppl_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);
    import ppl_pkg::*;

    localparam int NST       = 59;
    localparam int SQ_STEPS  = 27;
    localparam int DIV_STEPS = 16;

    typedef struct packed {
        logic [2:0][16:0] mag;
        logic [2:0]       neg;
    } t_vmag;

    typedef struct packed {
        logic [26:0] q;
        logic [27:0] rm;
    } t_sqs;

    typedef struct packed {
        logic [26:0]      len;
        logic             zero;
        logic [2:0]       neg;
        logic [2:0][26:0] rem;
        logic [2:0][15:0] quo;
    } t_dvs;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [REG_W-1:0] r_light, r_inten, r_amb, r_kd, r_ks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light <= '0;
            r_inten <= '0;
            r_amb   <= '0;
            r_kd    <= '0;
            r_ks    <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (t_reg_idx'(paddr[5:3]))
                REG_LIGHT_POS: r_light <= pwdata[REG_W-1:0];
                REG_INTENSITY: r_inten <= pwdata[REG_W-1:0];
                REG_AMBIENT:   r_amb   <= pwdata[REG_W-1:0];
                REG_DIFFUSE:   r_kd    <= pwdata[REG_W-1:0];
                REG_SPECULAR:  r_ks    <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Return register contents on reads
    always_comb begin
        unique case (t_reg_idx'(paddr[5:3]))
            REG_LIGHT_POS: prdata = DATA_W'(r_light);
            REG_INTENSITY: prdata = DATA_W'(r_inten);
            REG_AMBIENT:   prdata = DATA_W'(r_amb);
            REG_DIFFUSE:   prdata = DATA_W'(r_kd);
            REG_SPECULAR:  prdata = DATA_W'(r_ks);
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // ---------------------------------------------------------------
    // Helper functions
    // ---------------------------------------------------------------
    // One digit of the square root, two radicand bits per step
    function automatic t_sqs sqrt_step(t_sqs a, logic [33:0] s, int h);
        logic [53:0] xx;
        logic [29:0] rr;
        logic [29:0] t;
        t_sqs        o;
        xx = {s, 20'b0};
        rr = {a.rm, xx[h -: 2]};
        t  = {1'b0, a.q, 2'b01};
        if (rr >= t) begin
            o.rm = 28'(rr - t);
            o.q  = {a.q[25:0], 1'b1};
        end else begin
            o.rm = rr[27:0];
            o.q  = {a.q[25:0], 1'b0};
        end
        return o;
    endfunction

    // One quotient bit for each of the three components
    function automatic t_dvs div_step(t_dvs a);
        logic [27:0] t;
        t_dvs        o;
        o = a;
        for (int c = 0; c < 3; c++) begin
            t = {a.rem[c], 1'b0};
            if (t >= {1'b0, a.len}) begin
                o.rem[c] = 27'(t - {1'b0, a.len});
                o.quo[c] = {a.quo[c][14:0], 1'b1};
            end else begin
                o.rem[c] = t[26:0];
                o.quo[c] = {a.quo[c][14:0], 1'b0};
            end
        end
        return o;
    endfunction

    // Clamp a Q2.14 dot product to the range 0.0 .. 1.0
    function automatic logic [14:0] to_factor(logic signed [27:0] f);
        if (f < 0) begin
            return '0;
        end else if (f > 28'(UNIT_ONE)) begin
            return UNIT_ONE;
        end else begin
            return f[14:0];
        end
    endfunction

    // ---------------------------------------------------------------
    // Pipeline control and output skid
    // ---------------------------------------------------------------
    logic      r_vld [0:NST-1];
    logic      r_out_vld, r_skid_vld;
    t_out_item r_out, r_skid, w_res;
    logic      w_en, w_pop, w_last;

    assign w_en    = !r_skid_vld;
    assign w_pop   = r_out_vld && !i_stall;
    assign w_last  = r_vld[NST-1] && w_en;
    assign o_stall = r_skid_vld;
    assign o_valid = r_out_vld;
    assign o_out   = r_out;

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NST; i++) r_vld[i] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < NST; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    // Hold the result in the output slot, park it in the skid when stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_pop) r_skid_vld <= 1'b0;
        end else if (w_last) begin
            if (!r_out_vld || w_pop) r_out_vld  <= 1'b1;
            else                     r_skid_vld <= 1'b1;
        end else if (w_pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_pop) r_out <= r_skid;
        end else if (w_last) begin
            if (!r_out_vld || w_pop) r_out  <= w_res;
            else                     r_skid <= w_res;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: direction vectors as magnitude and sign
    // ---------------------------------------------------------------
    logic signed [15:0] w_p [3];
    logic signed [15:0] w_nr [3];
    logic signed [15:0] w_lc [3];
    logic signed [16:0] w_v [3][3];
    t_vmag              w_vm [3];
    t_vmag              r_in [3];

    always_comb begin
        w_p[0]  = i_in.pos_x;
        w_p[1]  = i_in.pos_y;
        w_p[2]  = i_in.pos_z;
        w_nr[0] = i_in.norm_x;
        w_nr[1] = i_in.norm_y;
        w_nr[2] = i_in.norm_z;
        for (int c = 0; c < 3; c++) begin
            w_lc[c]   = $signed(r_light[16*c +: 16]);
            w_v[0][c] = w_lc[c] - w_p[c];
            w_v[1][c] = -w_p[c];
            w_v[2][c] = w_nr[c];
        end
        for (int v = 0; v < 3; v++) begin
            for (int c = 0; c < 3; c++) begin
                w_vm[v].neg[c] = w_v[v][c][16];
                w_vm[v].mag[c] = w_v[v][c][16] ? 17'(-w_v[v][c]) : w_v[v][c];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stages 2-3: squares, then squared length
    // ---------------------------------------------------------------
    logic [33:0] r_sq [3][3];
    t_vmag       r_m2 [3];
    t_sqs        r_sx [0:SQ_STEPS][3];
    t_vmag       r_sv [0:SQ_STEPS][3];
    logic [33:0] r_ss [0:SQ_STEPS][3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int v = 0; v < 3; v++) begin
                r_in[v] <= w_vm[v];
                r_m2[v] <= r_in[v];
                for (int c = 0; c < 3; c++) begin
                    r_sq[v][c] <= 34'(r_in[v].mag[c]) * 34'(r_in[v].mag[c]);
                end
                r_ss[0][v] <= r_sq[v][0] + r_sq[v][1] + r_sq[v][2];
                r_sv[0][v] <= r_m2[v];
                r_sx[0][v] <= '0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Square root of s*2^20, one root bit per stage
    // ---------------------------------------------------------------
    for (genvar j = 1; j <= SQ_STEPS; j++) begin : g_sqrt
        localparam int H = 55 - 2*j;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                for (int v = 0; v < 3; v++) begin
                    r_sx[j][v] <= sqrt_step(r_sx[j-1][v], r_ss[j-1][v], H);
                    r_sv[j][v] <= r_sv[j-1][v];
                    r_ss[j][v] <= r_ss[j-1][v];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Divide each magnitude * 2^24 by the length, one bit per stage
    // ---------------------------------------------------------------
    t_dvs w_dv0 [3];
    t_dvs r_dv [1:DIV_STEPS][3];

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            w_dv0[v].len  = r_sx[SQ_STEPS][v].q;
            w_dv0[v].zero = (r_ss[SQ_STEPS][v] == '0);
            w_dv0[v].neg  = r_sv[SQ_STEPS][v].neg;
            for (int c = 0; c < 3; c++) begin
                w_dv0[v].rem[c] = {2'b0, r_sv[SQ_STEPS][v].mag[c], 8'b0};
                w_dv0[v].quo[c] = '0;
            end
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
        if (k == 1) begin : g_first
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    for (int v = 0; v < 3; v++) r_dv[k][v] <= div_step(w_dv0[v]);
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    for (int v = 0; v < 3; v++) r_dv[k][v] <= div_step(r_dv[k-1][v]);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Unit vectors, dot products, reflection, specular power, colour
    // ---------------------------------------------------------------
    logic signed [15:0] r_u [3][3];
    logic signed [31:0] r_nl [3];
    logic signed [15:0] r_l47 [3], r_e47 [3], r_n47 [3];
    logic signed [33:0] r_dnl;
    logic signed [15:0] r_l48 [3], r_e48 [3], r_n48 [3];
    logic signed [49:0] r_m [3];
    logic signed [15:0] r_l49 [3], r_e49 [3];
    logic [14:0]        r_fd49;
    logic signed [23:0] r_r [3];
    logic signed [15:0] r_e50 [3];
    logic [14:0]        r_fd50;
    logic signed [39:0] r_re [3];
    logic [14:0]        r_fd51;
    logic [14:0]        r_fsq [0:3];
    logic [14:0]        r_fdq [0:3];
    logic [29:0]        r_pa [3];
    logic [30:0]        r_pd [3], r_ps [3];
    logic [32:0]        r_sum [3];
    logic [48:0]        r_ip [3];

    logic signed [41:0] w_dre;
    logic [29:0]        w_fsq [1:3];

    always_comb begin
        w_dre = r_re[0] + r_re[1] + r_re[2];
        for (int i = 1; i <= 3; i++) w_fsq[i] = r_fsq[i-1] * r_fsq[i-1];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // apply signs, force a zero-length vector to zero
            for (int v = 0; v < 3; v++) begin
                for (int c = 0; c < 3; c++) begin
                    if (r_dv[DIV_STEPS][v].zero)
                        r_u[v][c] <= '0;
                    else if (r_dv[DIV_STEPS][v].neg[c])
                        r_u[v][c] <= -$signed(r_dv[DIV_STEPS][v].quo[c]);
                    else
                        r_u[v][c] <= $signed(r_dv[DIV_STEPS][v].quo[c]);
                end
            end
            // N.L products, then sum
            for (int c = 0; c < 3; c++) begin
                r_nl[c]  <= r_u[2][c] * r_u[0][c];
                r_l47[c] <= r_u[0][c];
                r_e47[c] <= r_u[1][c];
                r_n47[c] <= r_u[2][c];
                r_l48[c] <= r_l47[c];
                r_e48[c] <= r_e47[c];
                r_n48[c] <= r_n47[c];
            end
            r_dnl <= r_nl[0] + r_nl[1] + r_nl[2];
            // reflection R = 2(N.L)N - L
            for (int c = 0; c < 3; c++) begin
                r_m[c]   <= r_dnl * r_n48[c];
                r_l49[c] <= r_l48[c];
                r_e49[c] <= r_e48[c];
                r_r[c]   <= $signed(r_m[c][49:27]) - r_l49[c];
                r_e50[c] <= r_e49[c];
                r_re[c]  <= r_r[c] * r_e50[c];
            end
            r_fd49 <= to_factor(28'($signed(r_dnl[33:14])));
            r_fd50 <= r_fd49;
            r_fd51 <= r_fd50;
            // clamp R.E, then square three times
            r_fsq[0] <= to_factor(w_dre[41:14]);
            r_fdq[0] <= r_fd51;
            for (int i = 1; i <= 3; i++) begin
                r_fsq[i] <= w_fsq[i][28:14];
                r_fdq[i] <= r_fdq[i-1];
            end
            // per channel: ambient + kd*diffuse + ks*spec, times intensity
            for (int c = 0; c < 3; c++) begin
                r_pa[c]  <= {r_amb[16*c +: 16], 14'b0};
                r_pd[c]  <= 31'(r_kd[16*c +: 16]) * 31'(r_fdq[3]);
                r_ps[c]  <= 31'(r_ks[16*c +: 16]) * 31'(r_fsq[3]);
                r_sum[c] <= 33'(r_pa[c]) + 33'(r_pd[c]) + 33'(r_ps[c]);
                r_ip[c]  <= 49'(r_inten[16*c +: 16]) * 49'(r_sum[c]);
            end
        end
    end

    // Scale down and saturate
    always_comb begin
        w_res.red   = (r_ip[0][48:42] != '0) ? SAT_MAX : r_ip[0][41:26];
        w_res.green = (r_ip[1][48:42] != '0) ? SAT_MAX : r_ip[1][41:26];
        w_res.blue  = (r_ip[2][48:42] != '0) ? SAT_MAX : r_ip[2][41:26];
    end

endmodule

@@ hw/rtl/ppl_checker.sv @@
// Port-level checks for phong_pixel_lighting_top, attached by bind.
// Depends on ppl_pkg for the item types.
module ppl_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input ppl_pkg::t_out_item o_out
);
    import ppl_pkg::*;

    // Hold a stalled output transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("output transaction changed while stalled");

    // Drop all output and input stall after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output state not cleared by reset");

    // Input stall only while the output slot is full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output slot");

    // Input stall rises only after a stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stall without output backpressure");

endmodule

bind phong_pixel_lighting_top ppl_checker u_ppl_checker (.*);

@@ tb/sv/phong_pixel_lighting_top_tb.sv @@
// Self-checking testbench for phong_pixel_lighting_top: directed and random fragments,
// register settings through the APB port, shading predicted in fixed point and compared.
// Depends on ppl_pkg and phong_pixel_lighting_top.
module phong_pixel_lighting_top_tb;
    import ppl_pkg::*;

    localparam int LATENCY = 60;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    t_in_item            i_in;
    logic                o_valid;
    logic                i_stall;
    t_out_item           o_out;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Shadow copy of the light and material registers
    logic [REG_W-1:0]    shadow_regs [0:4];
    t_out_item           pixel_q [$];
    int                  n_errors;
    int                  send_idle_pct;
    int                  stall_pct;

    phong_pixel_lighting_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_in(i_in), .o_valid(o_valid), .i_stall(i_stall), .o_out(o_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Floor division by a power of two
    function automatic longint floor_shift(longint x, int k);
        return x >>> k;
    endfunction

    function automatic longint int_sqrt(longint unsigned x);
        longint unsigned rem, root, bitv;
        rem = x;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(root);
    endfunction

    // Scale a Q.12 vector to a Q2.14 unit vector; zero length gives zero
    function automatic void unit_vector(input longint v [3], output longint u [3]);
        longint unsigned sq;
        longint len;
        longint unsigned mag;
        longint q;
        sq = 0;
        for (int i = 0; i < 3; i++) sq += longint'(v[i] * v[i]);
        for (int i = 0; i < 3; i++) u[i] = 0;
        if (sq != 0) begin
            len = int_sqrt(sq << 20);
            for (int i = 0; i < 3; i++) begin
                mag = v[i] < 0 ? -v[i] : v[i];
                q = longint'((mag << 24) / len);
                u[i] = v[i] < 0 ? -q : q;
            end
        end
    endfunction

    function automatic longint clamp_factor(longint dq28);
        longint f;
        f = floor_shift(dq28, 14);
        if (f < 0) f = 0;
        if (f > 16384) f = 16384;
        return f;
    endfunction

    // Shade one fragment with the current register settings
    function automatic t_out_item shade_pixel(t_in_item frag);
        longint p [3], nr [3], lv [3], ev [3], l [3], e [3], n [3], r [3];
        longint dnl, fd, fs, amb, kd, ks, inten;
        longint unsigned sum, c;
        logic [15:0] ch [3];
        t_out_item res;
        p[0] = frag.pos_x;  p[1] = frag.pos_y;  p[2] = frag.pos_z;
        nr[0] = frag.norm_x; nr[1] = frag.norm_y; nr[2] = frag.norm_z;
        for (int i = 0; i < 3; i++) begin
            lv[i] = longint'($signed(shadow_regs[REG_LIGHT_POS][16*i +: 16])) - p[i];
            ev[i] = -p[i];
        end
        unit_vector(lv, l);
        unit_vector(ev, e);
        unit_vector(nr, n);
        dnl = n[0]*l[0] + n[1]*l[1] + n[2]*l[2];
        fd = clamp_factor(dnl);
        for (int i = 0; i < 3; i++) r[i] = floor_shift(2 * dnl * n[i], 28) - l[i];
        fs = clamp_factor(r[0]*e[0] + r[1]*e[1] + r[2]*e[2]);
        for (int i = 0; i < 3; i++) fs = (fs * fs) >> 14;
        for (int i = 0; i < 3; i++) begin
            amb = shadow_regs[REG_AMBIENT][16*i +: 16];
            kd = shadow_regs[REG_DIFFUSE][16*i +: 16];
            ks = shadow_regs[REG_SPECULAR][16*i +: 16];
            inten = shadow_regs[REG_INTENSITY][16*i +: 16];
            sum = (amb << 14) + kd * fd + ks * fs;
            c = ($unsigned(inten) * sum) >> 26;
            ch[i] = c > 65535 ? SAT_MAX : c[15:0];
        end
        res.red = ch[0];
        res.green = ch[1];
        res.blue = ch[2];
        return res;
    endfunction

    // Write one register over APB: setup then access; the caller ends the transfer
    task automatic write_reg(t_reg_idx idx, logic [REG_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(8 * idx);
        pwdata <= DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        shadow_regs[idx] = val;
    endtask

    // Wait until every pixel is back, then let the pipe drain
    task automatic drain_pipe();
        i_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic set_lighting(logic [REG_W-1:0] lp, logic [REG_W-1:0] it,
                                logic [REG_W-1:0] am, logic [REG_W-1:0] kd,
                                logic [REG_W-1:0] ks);
        drain_pipe();
        write_reg(REG_LIGHT_POS, lp);
        write_reg(REG_INTENSITY, it);
        write_reg(REG_AMBIENT, am);
        write_reg(REG_DIFFUSE, kd);
        write_reg(REG_SPECULAR, ks);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Send one fragment; queue its pixel when the transaction completes
    task automatic send_fragment(t_in_item frag);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in <= frag;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pixel_q.push_back(shade_pixel(frag));
    endtask

    function automatic t_in_item rand_fragment();
        t_in_item f;
        f = {$urandom, $urandom, $urandom};
        // Mostly modest positions so the lighting terms are not degenerate
        if ($urandom_range(3) != 0) begin
            f.pos_x = $signed(16'($urandom_range(16383))) - 16'sd8192;
            f.pos_y = $signed(16'($urandom_range(16383))) - 16'sd8192;
            f.pos_z = -$signed(16'($urandom_range(16383)));
        end
        return f;
    endfunction

    function automatic logic [REG_W-1:0] rand_reg(int maxv);
        return {16'($urandom_range(maxv)), 16'($urandom_range(maxv)),
                16'($urandom_range(maxv))};
    endfunction

    // Extremes of every field, zero vectors, facing and back-facing normals
    task automatic test_directed();
        t_in_item f;
        set_lighting({16'sh1000, 16'sh1000, 16'sh1000}, {3{16'h1000}},
                     {3{16'h0200}}, {3{16'h0800}}, {3{16'h0800}});
        f = '0;
        send_fragment(f);
        f = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
        send_fragment(f);
        f = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
        send_fragment(f);
        f = '{16'sh0000, 16'sh0000, -16'sh1000, 16'sh0000, 16'sh0000, 16'sh1000};
        send_fragment(f);
        f = '{16'sh0000, 16'sh0000, -16'sh1000, 16'sh0000, 16'sh0000, -16'sh1000};
        send_fragment(f);
        f = '{16'sh1000, 16'sh1000, 16'sh1000, 16'sh0000, 16'sh1000, 16'sh0000};
        send_fragment(f);
        f = '{16'sh0000, 16'sh0000, -16'sh2000, 16'sh0000, 16'sh0000, 16'sh0000};
        send_fragment(f);
        f = '{16'sh0001, -16'sh0001, -16'sh0001, 16'sh0001, 16'sh0001, 16'sh7FFF};
        send_fragment(f);
        // Saturate every channel
        set_lighting({16'sh7FFF, 16'sh8000, 16'sh7FFF}, {3{16'hFFFF}},
                     {3{16'hFFFF}}, {3{16'hFFFF}}, {3{16'hFFFF}});
        for (int i = 0; i < 6; i++) send_fragment(rand_fragment());
        f = '{16'sh0000, 16'sh0000, -16'sh1000, 16'sh0000, 16'sh0000, 16'sh1000};
        send_fragment(f);
        // All registers cleared
        set_lighting('0, '0, '0, '0, '0);
        for (int i = 0; i < 4; i++) send_fragment(rand_fragment());
    endtask

    // Random fragments under random settings, several idle patterns
    task automatic test_random();
        int idle_send [4] = '{0, 80, 0, 35};
        int idle_recv [4] = '{0, 0, 80, 35};
        for (int ph = 0; ph < 8; ph++) begin
            set_lighting(REG_W'({$urandom, $urandom}), rand_reg(ph % 2 ? 65535 : 8192),
                         rand_reg(2048), rand_reg(8192), rand_reg(16384));
            send_idle_pct = idle_send[ph % 4];
            stall_pct = idle_recv[ph % 4];
            for (int i = 0; i < 220; i++) send_fragment(rand_fragment());
        end
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    // Random receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
        end
    end

    // Compare each pixel with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pixel_q.size() == 0) begin
                $display("%0t: unexpected pixel %h", $time, o_out);
                n_errors++;
            end else begin
                want = pixel_q.pop_front();
                if (o_out.red !== want.red) begin
                    $display("%0t: red exp %h got %h", $time, want.red, o_out.red);
                    n_errors++;
                end
                if (o_out.green !== want.green) begin
                    $display("%0t: green exp %h got %h", $time, want.green, o_out.green);
                    n_errors++;
                end
                if (o_out.blue !== want.blue) begin
                    $display("%0t: blue exp %h got %h", $time, want.blue, o_out.blue);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        n_errors = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        for (int i = 0; i < 5; i++) shadow_regs[i] = '0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_in <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        drain_pipe();
        if (n_errors == 0 && pixel_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ phong_pixel_lighting_top.f @@
hw/rtl/ppl_pkg.sv
hw/rtl/phong_pixel_lighting_top.sv
hw/rtl/ppl_checker.sv
tb/sv/phong_pixel_lighting_top_tb.sv
